FILE: src/lmsfir_pkg.sv
// ----------------------------------------------------------------------------
// lmsfir_pkg: shared types and constants of the lms adaptive fir
// Sample format, payload structs, register codes and the command bundle
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsfir_pkg;

   // q1.15 samples, weights and results
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = SAMPLE_BITS - 1;
   localparam int FRAC_HALF   = 2 ** (FRAC_BITS - 1);

   // configuration registers
   localparam int TAP_COUNT_BITS = 6;
   localparam int STEP_BITS      = 15;
   localparam int STEP_HALF      = 2 ** (STEP_BITS - 1);
   localparam int CSR_DATA_BITS  = 15;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TAP_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_SIZE = 2'd1;

   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 6'd32;
   localparam logic [STEP_BITS-1:0]      STEP_SIZE_RESET = 15'd328;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic signed [15:0] source_sample;
      logic signed [15:0] reference_sample;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] filter_output;
      logic signed [15:0] error_value;
   } rsp_item_type;

   // command strobes from the controller
   typedef struct packed {
      logic load;      // take a new item, push sample, clear accumulator
      logic rd_filt;   // read tap for the filter pass
      logic rd_upd;    // read tap for the weight update pass
      logic calc_y;    // round and saturate the accumulator
      logic calc_e;    // reference minus output
      logic calc_gp;   // step size times error
      logic calc_g;    // round the gain
      logic load_rsp;  // move result into the output register
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: src/lms_adaptive_fir_core.sv
// ----------------------------------------------------------------------------
// lms_adaptive_fir_core: least-mean-squares adaptive fir filter
// Q1.15 adaptive filter with saturating output, error and weight update.
// ----------------------------------------------------------------------------
// Each request transfer carries one source sample and one reference sample and
// yields exactly one response transfer with the filter output and the error.
// An item occupies the block through these steps in order: taking the item,
// one read per active tap for the dot product, pipeline drain, rounding,
// error and gain, handing over the result (which waits while a previous
// response is still held), one read per active tap for the weight update and
// a final drain. The occupancy is set by the shared tap multiplier, which walks
// every active tap twice, and by the one read port of each of the delay line
// and weight memories. A finished response can wait in its output register
// while the next request is taken. Delay line and weights start at zero after
// reset by way of per-entry valid bits, so no clearing pass is needed.
// Register 0 is tap_count (0 acts as 1, values above MAX_TAPS act as
// MAX_TAPS), register 1 is step_size; writes to other indices are ignored.
// Configuration is expected to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_adaptive_fir_core #(
   parameter int MAX_TAPS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire lmsfir_pkg::req_item_type               req_payload,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output lmsfir_pkg::rsp_item_type                    rsp_payload,
   // configuration write port
   input  wire logic                                   csr_write_enable,
   input  wire logic [lmsfir_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lmsfir_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import lmsfir_pkg::*;

   localparam int IDX_W = $clog2(MAX_TAPS);

   // configuration registers
   logic [TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [STEP_BITS-1:0]      step_size_ff;

   // controller to datapath
   dp_cmd_type                cmd;
   logic [IDX_W-1:0]          tap_index;

   // plain register writes, unknown indices fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
         step_size_ff <= STEP_SIZE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TAP_COUNT: tap_count_ff <= csr_write_data[TAP_COUNT_BITS-1:0];
            REG_STEP_SIZE: step_size_ff <= csr_write_data[STEP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer: tap walks, result steps and response handshake
   lmsfir_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .tap_count (tap_count_ff),
      .cmd       (cmd),
      .tap_index (tap_index),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   // memories, shared multiplier and result registers
   lmsfir_datapath #(
      .MAX_TAPS (MAX_TAPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .tap_index (tap_index),
      .req_item  (req_payload),
      .step_size (step_size_ff),
      .rsp_item  (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: src/lmsfir_datapath.sv
// ----------------------------------------------------------------------------
// lmsfir_datapath: delay line, weights and shared multiply-accumulate
// Circular delay line and weight memories with valid bits, a tap pipeline
// (read data, product, weight delta) around one multiplier, and the output/error/gain registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsfir_datapath #(
   parameter int MAX_TAPS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire lmsfir_pkg::dp_cmd_type                 cmd,
   input  wire logic [$clog2(MAX_TAPS)-1:0]            tap_index,
   input  wire lmsfir_pkg::req_item_type               req_item,
   input  wire logic [lmsfir_pkg::STEP_BITS-1:0]       step_size,
   output lmsfir_pkg::rsp_item_type                    rsp_item
);
   import lmsfir_pkg::*;

   localparam int IDX_W  = $clog2(MAX_TAPS);
   localparam int G_W    = SAMPLE_BITS + 1;
   localparam int PROD_W = SAMPLE_BITS + G_W;
   localparam int D_W    = PROD_W + 1 - FRAC_BITS;
   localparam int ACC_W  = 2 * SAMPLE_BITS + IDX_W;
   localparam int SAT_W  = ACC_W + 1;
   localparam int GP_W   = STEP_BITS + 1 + SAMPLE_BITS;

   localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

   function automatic sample_type sat_sample(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] r;
      r = v;
      if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end
      return sample_type'(r[SAMPLE_BITS-1:0]);
   endfunction

   // memories
   sample_type            dly_mem [MAX_TAPS];
   sample_type            wgt_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]   dly_vld_ff;
   logic [MAX_TAPS-1:0]   wgt_vld_ff;

   logic [IDX_W-1:0]      head_ff;
   logic [IDX_W-1:0]      head_in;
   logic [IDX_W:0]        addr_sum;
   logic [IDX_W-1:0]      dly_raddr;
   logic                  rd_en;

   // stage 1: read data
   sample_type            dly_q_ff;
   sample_type            wgt_q_ff;
   logic                  dly_qv_ff;
   logic                  wgt_qv_ff;
   logic                  s1_filt_ff;
   logic                  s1_upd_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   sample_type            dly_s1;
   sample_type            wgt_s1;
   logic signed [G_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;

   // stage 2: product
   logic signed [PROD_W-1:0] prod_ff;
   sample_type            w2_ff;
   logic                  s2_filt_ff;
   logic                  s2_upd_ff;
   logic [IDX_W-1:0]      s2_idx_ff;
   logic signed [PROD_W:0] d_full;
   logic signed [PROD_W:0] d_shift;

   // stage 3: weight delta
   logic signed [D_W-1:0] d_ff;
   sample_type            w3_ff;
   logic                  s3_upd_ff;
   logic [IDX_W-1:0]      s3_idx_ff;
   logic signed [D_W:0]   w_sum;
   sample_type            w_new;

   // per-item registers
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W:0]   y_full;
   logic signed [ACC_W:0]   y_shift;
   sample_type              ref_ff;
   sample_type              y_ff;
   sample_type              e_ff;
   logic signed [SAMPLE_BITS:0] e_full;
   logic signed [GP_W-1:0]  gp_ff;
   logic signed [GP_W:0]    g_full;
   logic signed [GP_W:0]    g_shift;
   logic signed [G_W-1:0]   g_ff;
   rsp_item_type            rsp_ff;

   // newest sample sits at head, older ones follow upwards
   assign head_in   = (head_ff == '0) ? IDX_W'(MAX_TAPS - 1) : head_ff - 1'b1;
   assign addr_sum  = {1'b0, head_ff} + {1'b0, tap_index};
   assign dly_raddr = (addr_sum >= (IDX_W + 1)'(MAX_TAPS)) ?
                      IDX_W'(addr_sum - (IDX_W + 1)'(MAX_TAPS)) : addr_sum[IDX_W-1:0];
   assign rd_en     = cmd.rd_filt | cmd.rd_upd;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dly_mem[head_in] <= req_item.source_sample;
      end
      if (rd_en) begin
         dly_q_ff <= dly_mem[dly_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_upd_ff) begin
         wgt_mem[s3_idx_ff] <= w_new;
      end
      if (rd_en) begin
         wgt_q_ff <= wgt_mem[tap_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         dly_vld_ff <= '0;
         wgt_vld_ff <= '0;
         s1_filt_ff <= 1'b0;
         s1_upd_ff  <= 1'b0;
         s2_filt_ff <= 1'b0;
         s2_upd_ff  <= 1'b0;
         s3_upd_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            head_ff             <= head_in;
            dly_vld_ff[head_in] <= 1'b1;
         end
         if (s3_upd_ff) begin
            wgt_vld_ff[s3_idx_ff] <= 1'b1;
         end
         s1_filt_ff <= cmd.rd_filt;
         s1_upd_ff  <= cmd.rd_upd;
         s2_filt_ff <= s1_filt_ff;
         s2_upd_ff  <= s1_upd_ff;
         s3_upd_ff  <= s2_upd_ff;
      end
   end

   // unwritten entries read as zero
   assign dly_s1 = dly_qv_ff ? dly_q_ff : '0;
   assign wgt_s1 = wgt_qv_ff ? wgt_q_ff : '0;
   assign mul_b  = s1_upd_ff ? g_ff : G_W'(wgt_s1);
   assign prod   = PROD_W'(dly_s1) * PROD_W'(mul_b);

   assign d_full  = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(FRAC_HALF);
   assign d_shift = d_full >>> FRAC_BITS;

   assign w_sum = (D_W + 1)'(d_ff) + (D_W + 1)'(w3_ff);
   assign w_new = sat_sample(SAT_W'(w_sum));

   assign y_full  = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(FRAC_HALF);
   assign y_shift = y_full >>> FRAC_BITS;
   assign e_full  = (SAMPLE_BITS + 1)'(ref_ff) - (SAMPLE_BITS + 1)'(y_ff);
   assign g_full  = (GP_W + 1)'(gp_ff) + (GP_W + 1)'(STEP_HALF);
   assign g_shift = g_full >>> STEP_BITS;

   always_ff @(posedge clock) begin
      dly_qv_ff <= dly_vld_ff[dly_raddr];
      wgt_qv_ff <= wgt_vld_ff[tap_index];
      s1_idx_ff <= tap_index;
      prod_ff   <= prod;
      w2_ff     <= wgt_s1;
      s2_idx_ff <= s1_idx_ff;
      d_ff      <= D_W'(d_shift);
      w3_ff     <= w2_ff;
      s3_idx_ff <= s2_idx_ff;
      if (cmd.load) begin
         acc_ff <= '0;
         ref_ff <= req_item.reference_sample;
      end else if (s2_filt_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.calc_y) begin
         y_ff <= sat_sample(SAT_W'(y_shift));
      end
      if (cmd.calc_e) begin
         e_ff <= sat_sample(SAT_W'(e_full));
      end
      if (cmd.calc_gp) begin
         gp_ff <= GP_W'($signed({1'b0, step_size})) * GP_W'(e_ff);
      end
      if (cmd.calc_g) begin
         g_ff <= G_W'(g_shift);
      end
      if (cmd.load_rsp) begin
         rsp_ff.filter_output <= y_ff;
         rsp_ff.error_value   <= e_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

FILE: src/lmsfir_ctrl.sv
// ----------------------------------------------------------------------------
// lmsfir_ctrl: sequencer of the lms adaptive fir
// Walks the taps once for the filter and once for the update, steps the
// result arithmetic and owns the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsfir_ctrl #(
   parameter int MAX_TAPS = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [lmsfir_pkg::TAP_COUNT_BITS-1:0]   tap_count,
   output lmsfir_pkg::dp_cmd_type                       cmd,
   output logic [$clog2(MAX_TAPS)-1:0]                  tap_index,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready
);
   import lmsfir_pkg::*;

   localparam int IDX_W = $clog2(MAX_TAPS);
   localparam logic [1:0] FILT_DRAIN = 2'd1;
   localparam logic [1:0] UPD_DRAIN  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT,
      ST_FWAIT,
      ST_ROUND,
      ST_ERROR,
      ST_GAIN,
      ST_GROUND,
      ST_EMIT,
      ST_UPD,
      ST_UWAIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      cnt_wide;
   logic [IDX_W-1:0] taps_m1;

   // zero taps acts as one, oversized counts clamp to the built maximum
   assign cnt_wide = 32'(tap_count);
   always_comb begin
      if (tap_count == '0) begin
         taps_m1 = '0;
      end else if (cnt_wide > 32'(MAX_TAPS)) begin
         taps_m1 = IDX_W'(MAX_TAPS - 1);
      end else begin
         taps_m1 = IDX_W'(cnt_wide - 32'd1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = taps_m1;
               k_in     = '0;
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            cmd.rd_filt = 1'b1;
            if (k_ff == last_ff) begin
               k_in     = '0;
               cnt_in   = FILT_DRAIN;
               state_in = ST_FWAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_FWAIT: begin
            if (cnt_ff == '0) begin
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.calc_y = 1'b1;
            state_in   = ST_ERROR;
         end
         ST_ERROR: begin
            cmd.calc_e = 1'b1;
            state_in   = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.calc_gp = 1'b1;
            state_in    = ST_GROUND;
         end
         ST_GROUND: begin
            cmd.calc_g = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.rd_upd = 1'b1;
            if (k_ff == last_ff) begin
               k_in     = '0;
               cnt_in   = UPD_DRAIN;
               state_in = ST_UWAIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_UWAIT: begin
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         last_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign tap_index = k_ff;
   assign rsp_valid = rsp_valid_ff;

   // a new item always starts its filter pass at the newest tap
   a_start_at_tap0: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_FILT && k_ff == '0))
      else $error("filter pass did not start at tap zero");

   // tap walk never runs past the active tap count
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILT || state_ff == ST_UPD) |-> (k_ff <= last_ff))
      else $error("tap index beyond active taps");

   // active tap count stays within the built depth
   a_last_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (last_ff <= IDX_W'(MAX_TAPS - 1)))
      else $error("active tap count exceeds maximum");

   // loading the output register always raises valid on the next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire
